/* src/scsep_pkg.sv */
// ----------------------------------------------------------------------------
// scsep_pkg
// shared widths, codes and types of the shifted column separation unit
// ----------------------------------------------------------------------------
`default_nettype none

package scsep_pkg;

   localparam int MAX_ROWS    = 32;
   localparam int MAX_COLOURS = 8;

   localparam int VALUE_W  = 17;
   localparam int ROW_W    = 5;
   localparam int COL_W    = 3;
   localparam int K_W      = 4;
   localparam int SUM_W    = 24;
   localparam int FLAG_AW  = ROW_W + COL_W;
   localparam int FLAG_DEPTH = MAX_ROWS * MAX_COLOURS;

   localparam logic [SUM_W-1:0] SUM_MAX = '1;

   localparam logic KIND_LEADER = 1'b0;
   localparam logic KIND_MEMBER = 1'b1;

   typedef enum logic [8:0] {
      ST_IDLE  = 9'b000000001,
      ST_PREP  = 9'b000000010,
      ST_OPA   = 9'b000000100,
      ST_OPB   = 9'b000001000,
      ST_SUF   = 9'b000010000,
      ST_CHK   = 9'b000100000,
      ST_WADDR = 9'b001000000,
      ST_WDATA = 9'b010000000,
      ST_FLUSH = 9'b100000000
   } state_type;

   typedef enum logic {
      ALU_ADD = 1'b0,
      ALU_LT  = 1'b1
   } alu_op_type;

   typedef struct packed {
      logic             valid;
      logic             kind;
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] column;
      logic             last;
   } rsp_push_type;

   // entries in row r: min(r + 1, k)
   function automatic logic [K_W-1:0] row_width(input logic [ROW_W-1:0] r,
                                                input logic [K_W-1:0] k);
      logic [ROW_W:0] r1;
      r1 = {1'b0, r} + (ROW_W+1)'(1);
      if (r1 < (ROW_W+1)'(k)) begin
         return r1[K_W-1:0];
      end
      return k;
   endfunction

endpackage

`default_nettype wire

/* src/shifted_column_separation_unit.sv */
// ----------------------------------------------------------------------------
// shifted_column_separation_unit
// shifted column inequality separation over a triangular value stream
// ----------------------------------------------------------------------------
//
//   channel  direction  transfer contents
//   -------  ---------  ------------------------------------------------
//   csr      in         colour count k, written on csr_wr_en
//   req      in         one assignment value with its row and column
//   rsp      out        leader or member coordinate, tlast ends a report
//
// steps: an item in range runs prep, add and compare, and row zero ends there; column
//   zero ends after the suffix add, others after the suffix check; a violation adds an
//   address and a data step per traceback step over stored rows plus a flush to close
//   the report, set by the single shared adder/compare and the registered flag read
// out-of-range columns are dropped in the transfer cycle
// reset: synchronous, clears the sequencer, previous row minima, suffix sum,
//   row tracker, output valid; k returns to 8; flags are not cleared
// stalls: a held rsp transfer stops the traceback, req is not ready until
//   the item is finished; the output register decouples the last result
// ----------------------------------------------------------------------------
`default_nettype none

module shifted_column_separation_unit
   import scsep_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   // configuration
   input  logic           csr_wr_en,
   input  logic [K_W-1:0] csr_wr_data,     // num_colours
   // input stream
   input  logic           req_tvalid,
   output logic           req_tready,
   input  logic [31:0]    req_tdata,       // value[16:0], row[21:17], column[24:22], zero
   // result stream
   output logic           rsp_tvalid,
   input  logic           rsp_tready,
   output logic [7:0]     rsp_tdata,       // out_row[4:0], out_column[7:5]
   output logic           rsp_tuser,       // kind
   output logic           rsp_tlast        // last of one report
);

   logic [K_W-1:0]   num_colours_ff, num_colours_in;
   logic [K_W-1:0]   colours;

   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_kind_ff, rsp_kind_in;
   logic [ROW_W-1:0] rsp_row_ff, rsp_row_in;
   logic [COL_W-1:0] rsp_col_ff, rsp_col_in;
   logic             rsp_last_ff, rsp_last_in;

   logic             out_free;
   rsp_push_type     push;

   // register write, no read-back
   assign num_colours_in = csr_wr_en ? csr_wr_data : num_colours_ff;

   // k is clamped into the supported colour range
   always_comb begin
      if (num_colours_ff < K_W'(2)) begin
         colours = K_W'(2);
      end else if (num_colours_ff > K_W'(MAX_COLOURS)) begin
         colours = K_W'(MAX_COLOURS);
      end else begin
         colours = num_colours_ff;
      end
   end

   scsep_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .colours    (colours),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_value  (req_tdata[VALUE_W-1:0]),
      .req_row    (req_tdata[VALUE_W+ROW_W-1:VALUE_W]),
      .req_column (req_tdata[VALUE_W+ROW_W+COL_W-1:VALUE_W+ROW_W]),
      .out_free   (out_free),
      .push       (push)
   );

   // output register: free when empty or being taken this cycle
   assign out_free = ~rsp_valid_ff | rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_last_in  = rsp_last_ff;
      if (push.valid) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = push.kind;
         rsp_row_in   = push.row;
         rsp_col_in   = push.column;
         rsp_last_in  = push.last;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_colours_ff <= K_W'(MAX_COLOURS);
         rsp_valid_ff   <= 1'b0;
      end else begin
         num_colours_ff <= num_colours_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_kind_ff <= rsp_kind_in;
      rsp_row_ff  <= rsp_row_in;
      rsp_col_ff  <= rsp_col_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_col_ff, rsp_row_ff};
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire

/* src/scsep_alu.sv */
// ----------------------------------------------------------------------------
// scsep_alu
// shared 24-bit saturating adder and less-than compare on one carry chain
// ----------------------------------------------------------------------------
`default_nettype none

module scsep_alu
   import scsep_pkg::*;
(
   input  alu_op_type       op,
   input  logic [SUM_W-1:0] a,
   input  logic [SUM_W-1:0] b,
   output logic [SUM_W-1:0] sum,
   output logic             lt
);

   logic [SUM_W-1:0] b_eff;
   logic [SUM_W:0]   cin;
   logic [SUM_W:0]   total;

   always_comb begin
      unique case (op)
         ALU_ADD: begin
            b_eff = b;
            cin   = '0;
         end
         ALU_LT: begin
            b_eff = ~b;
            cin   = (SUM_W+1)'(1);
         end
         default: begin
            b_eff = b;
            cin   = '0;
         end
      endcase
      total = {1'b0, a} + {1'b0, b_eff} + cin;
      // carry out on add means overflow, on subtract it means a >= b
      sum   = total[SUM_W] ? SUM_MAX : total[SUM_W-1:0];
      lt    = ~total[SUM_W];
   end

endmodule

`default_nettype wire

/* src/scsep_flag_mem.sv */
// ----------------------------------------------------------------------------
// scsep_flag_mem
// choice flag store, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module scsep_flag_mem
   import scsep_pkg::*;
(
   input  logic               clock,
   input  logic               wr_en,
   input  logic [FLAG_AW-1:0] wr_addr,
   input  logic               wr_data,
   input  logic               rd_en,
   input  logic [FLAG_AW-1:0] rd_addr,
   output logic               rd_data
);

   logic mem [FLAG_DEPTH];
   logic rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* src/scsep_seq.sv */
// ----------------------------------------------------------------------------
// scsep_seq
// sequencer: row minima update, suffix check and flag traceback
// ----------------------------------------------------------------------------
`default_nettype none

module scsep_seq
   import scsep_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic [K_W-1:0]     colours,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [VALUE_W-1:0] req_value,
   input  logic [ROW_W-1:0]   req_row,
   input  logic [COL_W-1:0]   req_column,
   input  logic               out_free,
   output rsp_push_type       push
);

   state_type state_ff, state_in;

   logic [VALUE_W-1:0] val_ff, val_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic [COL_W-1:0]   col_ff, col_in;
   logic [ROW_W-1:0]   cur_row_ff, cur_row_in;
   logic [SUM_W-1:0]   suffix_ff, suffix_in;
   logic [SUM_W-1:0]   acc_ff, acc_in;
   logic [SUM_W-1:0]   prev_ff [MAX_COLOURS];
   logic [SUM_W-1:0]   prev_in [MAX_COLOURS];
   logic [SUM_W-1:0]   cur_ff  [MAX_COLOURS];
   logic [SUM_W-1:0]   cur_in  [MAX_COLOURS];
   logic [ROW_W-1:0]   walk_x_ff, walk_x_in;
   logic [COL_W-1:0]   walk_y_ff, walk_y_in;
   logic               pend_kind_ff, pend_kind_in;
   logic [ROW_W-1:0]   pend_row_ff, pend_row_in;
   logic [COL_W-1:0]   pend_col_ff, pend_col_in;

   alu_op_type         alu_op;
   logic [SUM_W-1:0]   alu_a, alu_b, alu_sum;
   logic               alu_lt;

   logic               flag_wr_en, flag_wr_data, flag_rd_en, flag_rd;
   logic [COL_W-1:0]   prev_sel;
   logic [SUM_W-1:0]   prev_rd;
   logic [K_W-1:0]     req_width, cur_width;

   scsep_alu u_alu (
      .op  (alu_op),
      .a   (alu_a),
      .b   (alu_b),
      .sum (alu_sum),
      .lt  (alu_lt)
   );

   scsep_flag_mem u_flags (
      .clock   (clock),
      .wr_en   (flag_wr_en),
      .wr_addr ({row_ff, col_ff}),
      .wr_data (flag_wr_data),
      .rd_en   (flag_rd_en),
      .rd_addr ({walk_x_ff, walk_y_ff}),
      .rd_data (flag_rd)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign req_width = row_width(req_row, colours);
   assign cur_width = row_width(cur_row_ff, colours);
   // same column in the add step, left neighbour in both compares
   assign prev_sel  = (state_ff == ST_OPA) ? col_ff : col_ff - COL_W'(1);
   assign prev_rd   = prev_ff[prev_sel];

   always_comb begin
      state_in     = state_ff;
      val_in       = val_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      cur_row_in   = cur_row_ff;
      suffix_in    = suffix_ff;
      acc_in       = acc_ff;
      prev_in      = prev_ff;
      cur_in       = cur_ff;
      walk_x_in    = walk_x_ff;
      walk_y_in    = walk_y_ff;
      pend_kind_in = pend_kind_ff;
      pend_row_in  = pend_row_ff;
      pend_col_in  = pend_col_ff;
      alu_op       = ALU_ADD;
      alu_a        = '0;
      alu_b        = '0;
      flag_wr_en   = 1'b0;
      flag_wr_data = 1'b0;
      flag_rd_en   = 1'b0;
      push         = '0;

      unique case (state_ff)
         ST_IDLE: begin
            // columns past the row width are dropped without a trace
            if (req_valid && (K_W'(req_column) < req_width)) begin
               val_in   = req_value;
               row_in   = req_row;
               col_in   = req_column;
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            if (row_ff == '0) begin
               for (int j = 0; j < MAX_COLOURS; j++) begin
                  prev_in[j] = '0;
                  cur_in[j]  = '0;
               end
               suffix_in  = '0;
               cur_row_in = '0;
            end else if (row_ff != cur_row_ff) begin
               for (int j = 0; j < MAX_COLOURS; j++) begin
                  prev_in[j] = (K_W'(j) < cur_width) ? cur_ff[j] : '0;
                  cur_in[j]  = '0;
               end
               suffix_in  = '0;
               cur_row_in = row_ff;
            end
            state_in = ST_OPA;
         end
         ST_OPA: begin
            // diagonal entry stands alone, others add the same column above
            alu_op   = ALU_ADD;
            alu_a    = (ROW_W'(col_ff) == row_ff) ? '0 : prev_rd;
            alu_b    = SUM_W'(val_ff);
            acc_in   = alu_sum;
            state_in = ST_OPB;
         end
         ST_OPB: begin
            alu_op     = ALU_LT;
            alu_a      = acc_ff;
            alu_b      = prev_rd;
            flag_wr_en = 1'b1;
            if (col_ff == '0) begin
               cur_in[0]    = acc_ff;
               flag_wr_data = 1'b1;
            end else begin
               cur_in[col_ff] = alu_lt ? acc_ff : prev_rd;
               flag_wr_data   = alu_lt;
            end
            state_in = (row_ff == '0) ? ST_IDLE : ST_SUF;
         end
         ST_SUF: begin
            alu_op    = ALU_ADD;
            alu_a     = suffix_ff;
            alu_b     = SUM_W'(val_ff);
            suffix_in = alu_sum;
            state_in  = (col_ff == '0) ? ST_IDLE : ST_CHK;
         end
         ST_CHK: begin
            alu_op = ALU_LT;
            alu_a  = prev_rd;
            alu_b  = suffix_ff;
            if (alu_lt) begin
               pend_kind_in = KIND_LEADER;
               pend_row_in  = row_ff;
               pend_col_in  = col_ff;
               walk_x_in    = row_ff - ROW_W'(1);
               walk_y_in    = col_ff - COL_W'(1);
               state_in     = ST_WADDR;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_WADDR: begin
            flag_rd_en = 1'b1;
            state_in   = ST_WDATA;
         end
         ST_WDATA: begin
            if (flag_rd) begin
               // a new member is found, so the held one is not the last
               if (out_free) begin
                  push.valid   = 1'b1;
                  push.kind    = pend_kind_ff;
                  push.row     = pend_row_ff;
                  push.column  = pend_col_ff;
                  push.last    = 1'b0;
                  pend_kind_in = KIND_MEMBER;
                  pend_row_in  = walk_x_ff;
                  pend_col_in  = walk_y_ff;
                  if (ROW_W'(walk_y_ff) == walk_x_ff) begin
                     state_in = ST_FLUSH;
                  end else begin
                     walk_x_in = walk_x_ff - ROW_W'(1);
                     state_in  = ST_WADDR;
                  end
               end
            end else if (walk_y_ff == '0) begin
               state_in = ST_FLUSH;
            end else begin
               walk_x_in = walk_x_ff - ROW_W'(1);
               walk_y_in = walk_y_ff - COL_W'(1);
               state_in  = ST_WADDR;
            end
         end
         ST_FLUSH: begin
            if (out_free) begin
               push.valid  = 1'b1;
               push.kind   = pend_kind_ff;
               push.row    = pend_row_ff;
               push.column = pend_col_ff;
               push.last   = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         cur_row_ff <= '0;
         suffix_ff  <= '0;
         for (int j = 0; j < MAX_COLOURS; j++) begin
            prev_ff[j] <= '0;
         end
      end else begin
         state_ff   <= state_in;
         cur_row_ff <= cur_row_in;
         suffix_ff  <= suffix_in;
         prev_ff    <= prev_in;
      end
   end

   always_ff @(posedge clock) begin
      val_ff       <= val_in;
      row_ff       <= row_in;
      col_ff       <= col_in;
      acc_ff       <= acc_in;
      cur_ff       <= cur_in;
      walk_x_ff    <= walk_x_in;
      walk_y_ff    <= walk_y_in;
      pend_kind_ff <= pend_kind_in;
      pend_row_ff  <= pend_row_in;
      pend_col_ff  <= pend_col_in;
   end

   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      push.valid |-> out_free)
      else $error("result pushed into a full output register");

   a_walk_in_triangle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WADDR) |-> (ROW_W'(walk_y_ff) <= walk_x_ff))
      else $error("traceback left the triangle");

   a_hit_starts_walk: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CHK && alu_lt) |=>
         (state_ff == ST_WADDR && pend_kind_ff == KIND_LEADER))
      else $error("violation did not start a traceback with its leader");

   a_walk_keeps_rows: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WDATA) |=> ($stable(suffix_ff) && $stable(cur_row_ff)))
      else $error("row state changed during traceback");

endmodule

`default_nettype wire

/* verif/tb_shifted_column_separation_unit.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_shifted_column_separation_unit
// self-checking bench for the shifted column separation unit
// ----------------------------------------------------------------------------
// A directed table, then a short run of repeated column zero, then random
// phases under several colour counts. Phases mostly carry well-formed
// triangular frames with random values, mixed with stray coordinates,
// skipped columns, row gaps and descents. Each accepted transfer goes
// through a bit-true predictor of the separation step, and every reported
// coordinate is compared field by field. The sender runs in bursts, the
// receiver stalls on its own pattern and holds off once for a long stretch.
// ----------------------------------------------------------------------------

module tb_shifted_column_separation_unit;
   import scsep_pkg::*;

   localparam int CYCLE_LIMIT = 500000;
   localparam int IDLE_TAIL   = 40;
   localparam int DRAIN_LIMIT = 20000;
   localparam int LONG_HOLD   = 400;
   localparam int TABLE_ROWS  = 20;

   typedef struct packed {
      logic             kind;
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] column;
      logic             last;
   } coord_type;

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic [ROW_W-1:0]   row;
      logic [COL_W-1:0]   column;
      logic               typed;
      logic [1:0]         n_typed;
      coord_type          first;
      coord_type          second;
   } stim_row_type;

   typedef enum logic [1:0] {
      RX_OPEN,
      RX_COIN,
      RX_THIRD,
      RX_MOSTLY
   } rx_mode_type;

   localparam logic CHECK_PREDICTED = 1'b0;
   localparam logic CHECK_TYPED     = 1'b1;

   localparam coord_type NO_COORD    = '0;
   localparam coord_type ROW1_LEADER = '{KIND_LEADER, 5'd1, 3'd0 + 3'd1, 1'b0};
   localparam coord_type ORIGIN_LAST = '{KIND_MEMBER, 5'd0, 3'd0, 1'b1};

   logic               clock       = 1'b0;
   logic               reset       = 1'b1;
   logic               csr_wr_en   = 1'b0;
   logic [K_W-1:0]     csr_wr_data = '0;
   logic               req_tvalid  = 1'b0;
   logic               req_tready;
   logic [31:0]        req_tdata   = '0;
   logic               rsp_tvalid;
   logic               rsp_tready  = 1'b0;
   logic [7:0]         rsp_tdata;
   logic               rsp_tuser;
   logic               rsp_tlast;

   // predictor state
   logic [K_W-1:0]     colour_reg = 4'd8;
   logic [SUM_W-1:0]   prev_min [MAX_COLOURS];
   logic [SUM_W-1:0]   cur_min [MAX_COLOURS];
   logic               flag_mem [FLAG_DEPTH];
   bit                 flag_known [FLAG_DEPTH];
   logic [SUM_W-1:0]   suffix_acc = '0;
   logic [ROW_W-1:0]   row_now = '0;

   coord_type          expected_coords [$];

   // frame generator
   int                 gen_row, gen_col, frame_top;
   int                 burst_left = 0;

   // receiver
   int unsigned        rx_cycle = 0;
   int                 hold_left = 0;
   bit                 hold_arm = 1'b0;
   bit                 hold_done = 1'b0;
   coord_type          got_coord, want_coord;

   // bookkeeping
   int unsigned        cycle_count = 0;
   int                 failures = 0;
   int                 items_accepted = 0;
   int                 coords_seen = 0;
   int                 reports = 0;
   int                 longest_report = 0;
   int                 settings_done = 0;

   stim_row_type directed_rows [0:TABLE_ROWS-1] = '{
      // stray column on row zero, dropped
      '{17'd5,     5'd0, 3'd1, CHECK_TYPED,     2'd0, NO_COORD,    NO_COORD},
      '{17'd0,     5'd0, 3'd0, CHECK_TYPED,     2'd0, NO_COORD,    NO_COORD},
      // diagonal above a zero minimum: leader, then the origin
      '{17'd1,     5'd1, 3'd1, CHECK_TYPED,     2'd2, ROW1_LEADER, ORIGIN_LAST},
      '{17'd65536, 5'd1, 3'd0, CHECK_TYPED,     2'd0, NO_COORD,    NO_COORD},
      '{17'd0,     5'd1, 3'd2, CHECK_TYPED,     2'd0, NO_COORD,    NO_COORD},
      '{17'd0,     5'd2, 3'd2, CHECK_TYPED,     2'd0, NO_COORD,    NO_COORD},
      '{17'd65536, 5'd2, 3'd1, CHECK_PREDICTED, 2'd0, NO_COORD,    NO_COORD},
      '{17'd0,     5'd2, 3'd0, CHECK_TYPED,     2'd0, NO_COORD,    NO_COORD},
      // full row at value 65536, the largest the bench picks
      '{17'd65536, 5'd3, 3'd3, CHECK_PREDICTED, 2'd0, NO_COORD,    NO_COORD},
      '{17'd65536, 5'd3, 3'd2, CHECK_PREDICTED, 2'd0, NO_COORD,    NO_COORD},
      '{17'd65536, 5'd3, 3'd1, CHECK_PREDICTED, 2'd0, NO_COORD,    NO_COORD},
      '{17'd65536, 5'd3, 3'd0, CHECK_PREDICTED, 2'd0, NO_COORD,    NO_COORD},
      // columns out of order, one repeated
      '{17'd1000,  5'd4, 3'd1, CHECK_PREDICTED, 2'd0, NO_COORD,    NO_COORD},
      '{17'd2000,  5'd4, 3'd4, CHECK_PREDICTED, 2'd0, NO_COORD,    NO_COORD},
      '{17'd0,     5'd4, 3'd1, CHECK_PREDICTED, 2'd0, NO_COORD,    NO_COORD},
      '{17'd65536, 5'd4, 3'd0, CHECK_TYPED,     2'd0, NO_COORD,    NO_COORD},
      // descent in row number closes row four
      '{17'd100,   5'd2, 3'd1, CHECK_PREDICTED, 2'd0, NO_COORD,    NO_COORD},
      // restart in the middle of a frame
      '{17'd7,     5'd0, 3'd0, CHECK_TYPED,     2'd0, NO_COORD,    NO_COORD},
      '{17'd65536, 5'd1, 3'd1, CHECK_TYPED,     2'd2, ROW1_LEADER, ORIGIN_LAST},
      '{17'd12345, 5'd1, 3'd0, CHECK_TYPED,     2'd0, NO_COORD,    NO_COORD}
   };

   shifted_column_separation_unit i_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // predictor
   // ------------------------------------------------------------------------

   function automatic int colours_now();
      if (colour_reg < 4'd2) begin
         return 2;
      end
      if (colour_reg > 4'(MAX_COLOURS)) begin
         return MAX_COLOURS;
      end
      return int'(colour_reg);
   endfunction

   function automatic int cells_in_row(input int r, input int kk);
      return (r + 1 < kk) ? r + 1 : kk;
   endfunction

   function automatic logic [SUM_W-1:0] sat24(input logic [SUM_W-1:0] a,
                                              input logic [SUM_W-1:0] b);
      logic [SUM_W:0] t;
      t = {1'b0, a} + {1'b0, b};
      return t[SUM_W] ? SUM_MAX : t[SUM_W-1:0];
   endfunction

   function automatic coord_type coord(input logic kind, input int r, input int c);
      coord_type e;
      e.kind   = kind;
      e.row    = ROW_W'(r);
      e.column = COL_W'(c);
      e.last   = 1'b0;
      return e;
   endfunction

   // one separation step; -1 when the traceback would touch a flag that was
   // never written, otherwise the number of coordinates reported
   function automatic int predict_separation(input logic [VALUE_W-1:0] val,
                                             input logic [ROW_W-1:0] r,
                                             input logic [COL_W-1:0] c,
                                             input bit commit,
                                             input bit push);
      logic [SUM_W-1:0] pv [MAX_COLOURS];
      logic [SUM_W-1:0] cu [MAX_COLOURS];
      logic [SUM_W-1:0] sfx;
      logic [SUM_W-1:0] s;
      logic [SUM_W-1:0] v24;
      logic [ROW_W-1:0] crow;
      logic             take;
      coord_type        tail;
      coord_type        found [$];
      int               kk, w, x, y, j, ci, at;
      kk  = colours_now();
      ci  = int'(c);
      v24 = SUM_W'(val);
      if (ci >= cells_in_row(int'(r), kk)) begin
         return 0;
      end
      pv   = prev_min;
      cu   = cur_min;
      sfx  = suffix_acc;
      crow = row_now;
      if (r == '0) begin
         for (j = 0; j < MAX_COLOURS; j++) begin
            pv[j] = '0;
            cu[j] = '0;
         end
         sfx   = '0;
         crow  = '0;
         cu[0] = v24;
         take  = 1'b1;
      end else begin
         if (r != crow) begin
            w = cells_in_row(int'(crow), kk);
            for (j = 0; j < MAX_COLOURS; j++) begin
               pv[j] = (j < w) ? cu[j] : '0;
               cu[j] = '0;
            end
            sfx  = '0;
            crow = r;
         end
         if (ci == 0) begin
            cu[0] = sat24(pv[0], v24);
            take  = 1'b1;
         end else begin
            // diagonal entry has nothing above it in its own column
            s = (ci == int'(r)) ? v24 : sat24(pv[ci], v24);
            take   = (s < pv[ci-1]);
            cu[ci] = take ? s : pv[ci-1];
         end
         sfx = sat24(sfx, v24);
         if (ci != 0 && sfx > pv[ci-1]) begin
            found.push_back(coord(KIND_LEADER, int'(r), ci));
            x = int'(r) - 1;
            y = ci - 1;
            while (x >= 0 && y >= 0 && y <= x) begin
               at = x * MAX_COLOURS + y;
               if (!flag_known[at]) begin
                  return -1;
               end
               if (flag_mem[at]) begin
                  found.push_back(coord(KIND_MEMBER, x, y));
                  x--;
               end else begin
                  x--;
                  y--;
               end
            end
            tail      = found.pop_back();
            tail.last = 1'b1;
            found.push_back(tail);
         end
      end
      if (commit) begin
         prev_min   = pv;
         cur_min    = cu;
         suffix_acc = sfx;
         row_now    = crow;
         at = int'(r) * MAX_COLOURS + ci;
         flag_mem[at]   = take;
         flag_known[at] = 1'b1;
         if (found.size() != 0) begin
            reports++;
         end
         if (found.size() > longest_report) begin
            longest_report = found.size();
         end
      end
      if (push) begin
         foreach (found[i]) begin
            expected_coords.push_back(found[i]);
         end
      end
      return found.size();
   endfunction

   // ------------------------------------------------------------------------
   // sender
   // ------------------------------------------------------------------------

   task automatic offer_item(input logic [VALUE_W-1:0] v, input logic [ROW_W-1:0] r,
                             input logic [COL_W-1:0] c, input logic typed);
      int gap;
      int unused;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(1, 8);
      end
      burst_left--;
      req_tdata  <= {7'd0, c, r, v};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      // typed rows update the state here, their coordinates come from the table
      unused = predict_separation(v, r, c, 1'b1, typed == CHECK_PREDICTED);
      items_accepted++;
   endtask

   // drop valid and wait until every report is in and the unit has gone quiet
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_coords.size() != 0) @(posedge clock);
      repeat (IDLE_TAIL) @(posedge clock);
   endtask

   task automatic write_colours(input logic [K_W-1:0] k);
      settle();
      csr_wr_data <= k;
      csr_wr_en   <= 1'b1;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      colour_reg = k;
      settings_done++;
   endtask

   function automatic logic [VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return 17'd65536;
         4:       return VALUE_W'($urandom_range(0, 2048));
         5:       return VALUE_W'($urandom_range(30000, 65536));
         default: return VALUE_W'($urandom_range(0, 65536));
      endcase
   endfunction

   function automatic int pick_top();
      return ($urandom_range(0, 7) == 0) ? $urandom_range(8, 31) : $urandom_range(1, 6);
   endfunction

   // step the frame walk past entry (r, c): next column down, else next row, or a new frame after the top row
   function automatic void advance_frame(input int r, input int c);
      if (c != 0) begin
         gen_col = c - 1;
      end else if (r >= frame_top) begin
         gen_row   = 0;
         gen_col   = 0;
         frame_top = pick_top();
      end else begin
         gen_row = r + 1;
         gen_col = cells_in_row(gen_row, colours_now()) - 1;
      end
   endfunction

   task automatic random_phase(input logic [K_W-1:0] k, input int n_items,
                               input int first_top, input bit with_hold);
      logic [VALUE_W-1:0] v;
      logic [ROW_W-1:0]   r;
      logic [COL_W-1:0]   c;
      int                 sent;
      int                 pick;
      bit                 framed;
      write_colours(k);
      if (with_hold) begin
         hold_arm = 1'b1;
      end
      gen_row   = 0;
      gen_col   = 0;
      frame_top = (first_top != 0) ? first_top : pick_top();
      sent      = 0;
      while (sent < n_items) begin
         v      = pick_value();
         pick   = $urandom_range(0, 19);
         framed = 1'b1;
         if (pick < 2) begin
            // stray coordinate anywhere in the field ranges
            r      = ROW_W'($urandom_range(0, 31));
            c      = COL_W'($urandom_range(0, 7));
            framed = 1'b0;
         end else begin
            if (pick == 2) begin
               // abandon the rest of this row
               advance_frame(gen_row, 0);
            end
            r = ROW_W'(gen_row);
            c = COL_W'(gen_col);
         end
         if (predict_separation(v, r, c, 1'b0, 1'b0) < 0) begin
            // would walk into unwritten flags: start a fresh frame instead
            r         = '0;
            c         = '0;
            framed    = 1'b1;
            frame_top = pick_top();
         end
         offer_item(v, r, c, CHECK_PREDICTED);
         if (int'(c) < cells_in_row(int'(r), colours_now())) begin
            sent++;
         end
         if (framed) begin
            advance_frame(int'(r), int'(c));
         end
      end
   endtask

   initial begin
      int i;
      int drain;
      int left;
      foreach (prev_min[j]) begin
         prev_min[j] = '0;
         cur_min[j]  = '0;
      end
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed table at the reset colour count
      for (i = 0; i < TABLE_ROWS; i++) begin
         offer_item(directed_rows[i].value, directed_rows[i].row,
                    directed_rows[i].column, directed_rows[i].typed);
         if (directed_rows[i].typed == CHECK_TYPED) begin
            if (directed_rows[i].n_typed >= 2'd1) begin
               expected_coords.push_back(directed_rows[i].first);
            end
            if (directed_rows[i].n_typed >= 2'd2) begin
               expected_coords.push_back(directed_rows[i].second);
            end
         end
      end

      // pile column zero of row one so the suffix sum keeps growing,
      // then the top column must see it as a violation
      for (i = 0; i < 8; i++) begin
         offer_item(17'd65536, 5'd1, 3'd0, CHECK_PREDICTED);
      end
      offer_item(17'd0, 5'd1, 3'd1, CHECK_PREDICTED);

      // random phases; out-of-range counts clamp to the extremes
      random_phase(4'd2, 24, 31, 1'b0);
      random_phase(4'd15, 10, 8, 1'b0);
      random_phase(4'd0, 8, 0, 1'b0);
      random_phase(4'd8, 24, 8, 1'b1);
      random_phase(4'd1, 8, 0, 1'b0);
      random_phase(4'd9, 8, 0, 1'b0);
      random_phase(K_W'($urandom_range(3, 7)), 10, 0, 1'b0);

      req_tvalid <= 1'b0;
      drain = 0;
      while (expected_coords.size() != 0 && drain < DRAIN_LIMIT) begin
         @(posedge clock);
         drain++;
      end
      repeat (IDLE_TAIL) @(posedge clock);
      left = expected_coords.size();
      if (left != 0) begin
         failures += left;
         $display("%0t: %0d expected coordinates never arrived", $time, left);
      end

      $display("covered %0d transfers over %0d colour counts, %0d violation reports",
               items_accepted, settings_done + 1, reports);
      $display("checked %0d coordinates, longest report %0d, one long receiver hold",
               coords_seen, longest_report);
      if (failures == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // ------------------------------------------------------------------------
   // receiver and checker
   // ------------------------------------------------------------------------

   function automatic void compare_field(input string what, input int want, input int got);
      if (want != got) begin
         failures++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      end
   endfunction

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got_coord = '{rsp_tuser, rsp_tdata[4:0], rsp_tdata[7:5], rsp_tlast};
            coords_seen++;
            if (expected_coords.size() == 0) begin
               failures++;
               $display("%0t: unexpected transfer kind %0d row %0d column %0d last %0d",
                        $time, got_coord.kind, got_coord.row, got_coord.column,
                        got_coord.last);
            end else begin
               want_coord = expected_coords.pop_front();
               compare_field("kind", want_coord.kind, got_coord.kind);
               compare_field("row", want_coord.row, got_coord.row);
               compare_field("column", want_coord.column, got_coord.column);
               compare_field("last", want_coord.last, got_coord.last);
            end
         end
         rx_cycle++;
         if (hold_arm && !hold_done) begin
            hold_left = LONG_HOLD;
            hold_done = 1'b1;
         end
         if (hold_left != 0) begin
            // long hold-off, the unit must back up into its input
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            case (rx_mode_type'(rx_cycle[8:7]))
               RX_OPEN:   rsp_tready <= 1'b1;
               RX_COIN:   rsp_tready <= ($urandom_range(0, 1) == 1);
               RX_THIRD:  rsp_tready <= (rx_cycle % 3 == 0);
               RX_MOSTLY: rsp_tready <= ($urandom_range(0, 7) != 0);
            endcase
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: cycle limit reached", $time);
         $display("simulation failed");
         $finish;
      end
   end

endmodule
